// ===== hw/rtl/dnsa_pkg.sv =====
// Shared types and constants for the DNS A-record response parser.
`default_nettype none

package dnsa_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 4;

  // Field positions within the header and the fixed answer part
  localparam logic [CNT_W-1:0] HDR_ID_LO    = 4'd1;
  localparam logic [CNT_W-1:0] HDR_FLAGS_LO = 4'd3;
  localparam logic [CNT_W-1:0] HDR_QD_LO    = 4'd5;
  localparam logic [CNT_W-1:0] HDR_AN_LO    = 4'd7;
  localparam logic [CNT_W-1:0] HDR_LAST     = 4'd11;
  localparam logic [CNT_W-1:0] QTAIL_LEN    = 4'd4;
  localparam logic [CNT_W-1:0] FIX_TYPE_LO  = 4'd1;
  localparam logic [CNT_W-1:0] FIX_CLASS_LO = 4'd3;
  localparam logic [CNT_W-1:0] FIX_LAST     = 4'd9;
  localparam logic [CNT_W-1:0] A_RDLEN      = 4'd4;

  localparam logic [WORD_W-1:0] TYPE_A   = 16'd1;
  localparam logic [WORD_W-1:0] CLASS_IN = 16'd1;

  localparam logic [WORD_W-1:0] FLAG_QR    = 16'h8000;
  localparam logic [WORD_W-1:0] FLAG_TC    = 16'h0200;
  localparam logic [WORD_W-1:0] RCODE_MASK = 16'h000F;

  localparam logic [BYTE_W-1:0] PTR_MASK = 8'hC0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dnsa_if.sv =====
// Valid/ready channel interfaces for packet bytes and parse results.
`default_nettype none

interface dnsa_in_if import dnsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsa_out_if import dnsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output status, output address, input ready);
  modport sink   (input valid, input status, input address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dns_a_response_parser.sv =====
// Top level: byte-serial DNS response parser that extracts the first A/IN address.
//
// Usage: packet bytes of a DNS response enter on in_ch, one item per byte, with
// last_byte set on the final byte. cfg_we/cfg_wdata set the expected query id;
// write it only between packets. At most one result item per packet leaves on
// out_ch: status ok with the address, invalid, or truncated when the packet ends
// before the outcome is known. Bytes after a decision are dropped until the end
// of the packet.
// Timing: an accepted byte sits in the input register and is parsed at the edge
// that moves it on, which loads its result, if any, into the output register that
// drives out_ch.valid. One byte is taken per cycle while out_ch does not stall:
// the per-byte state update is a single registered step between the two registers.
// Stall: while a result waits unaccepted in the output register the byte in the
// input register holds, and in_ch.ready drops once the input register is full.
// Reset: rst_n (synchronous, active low) clears the packet state, both valid
// flags and the expected id.
`default_nettype none

module dns_a_response_parser import dnsa_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  dnsa_in_if.sink              in_ch,
  dnsa_out_if.source           out_ch,
  input  wire logic            cfg_we,
  input  wire logic [ID_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QTAIL,
    PH_ANAME_FIRST,
    PH_ANAME_REST,
    PH_APTR,
    PH_FIXED,
    PH_ADDR,
    PH_SKIP
  } phase_t;

  logic [ID_W-1:0]   expected_id_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_address_r;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [WORD_W-1:0] questions_left_r, questions_left_nxt;
  logic [WORD_W-1:0] answers_left_r, answers_left_nxt;
  logic [WORD_W-1:0] field_word_r, field_word_nxt;
  logic [WORD_W-1:0] answer_type_r, answer_type_nxt;
  logic [WORD_W-1:0] answer_class_r, answer_class_nxt;
  logic [ADDR_W-1:0] address_acc_r, address_acc_nxt;
  logic              decided_r, decided_nxt;

  logic              s1_fire;
  logic              in_fire;
  logic              res_valid;
  status_t           res_status;
  logic [ADDR_W-1:0] res_address;

  logic              hit;
  status_t           hit_status;
  logic [WORD_W-1:0] fw_shift;
  logic [WORD_W-1:0] fw_dec;
  logic [WORD_W-1:0] an_dec;
  logic [WORD_W-1:0] qd_dec;
  logic [CNT_W-1:0]  bc_inc;
  logic [ADDR_W-1:0] acc_shift;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.address = out_address_r;

  assign fw_shift  = {field_word_r[WORD_W-BYTE_W-1:0], s1_byte_r};
  assign fw_dec    = field_word_r - 16'd1;
  assign an_dec    = answers_left_r - 16'd1;
  assign qd_dec    = questions_left_r - 16'd1;
  assign bc_inc    = byte_count_r + 4'd1;
  assign acc_shift = {address_acc_r[ADDR_W-BYTE_W-1:0], s1_byte_r};

  always_comb begin
    phase_nxt          = phase_r;
    byte_count_nxt     = byte_count_r;
    questions_left_nxt = questions_left_r;
    answers_left_nxt   = answers_left_r;
    field_word_nxt     = field_word_r;
    answer_type_nxt    = answer_type_r;
    answer_class_nxt   = answer_class_r;
    address_acc_nxt    = address_acc_r;
    decided_nxt        = decided_r;
    hit                = 1'b0;
    hit_status         = ST_INVALID;
    res_valid          = 1'b0;
    res_status         = ST_TRUNC;
    res_address        = '0;

    if (s1_fire && !decided_r) begin
      case (phase_r)
        PH_HEADER: begin
          field_word_nxt = fw_shift;
          byte_count_nxt = bc_inc;
          if (byte_count_r == HDR_ID_LO) begin
            if (fw_shift != expected_id_r) answer_type_nxt = 16'd1;
          end else if (byte_count_r == HDR_FLAGS_LO) begin
            if ((fw_shift & FLAG_QR) == '0 || (fw_shift & FLAG_TC) != '0 ||
                (fw_shift & RCODE_MASK) != '0)
              answer_type_nxt = 16'd1;
          end else if (byte_count_r == HDR_QD_LO) begin
            questions_left_nxt = fw_shift;
          end else if (byte_count_r == HDR_AN_LO) begin
            answers_left_nxt = fw_shift;
          end else if (byte_count_r == HDR_LAST) begin
            if (answer_type_r != '0 || answers_left_r == '0) begin
              hit = 1'b1;
            end else begin
              answer_type_nxt = '0;
              field_word_nxt  = '0;
              byte_count_nxt  = '0;
              phase_nxt = (questions_left_r != '0) ? PH_QNAME : PH_ANAME_FIRST;
            end
          end
        end
        PH_QNAME: begin
          if (s1_byte_r == '0) begin
            phase_nxt      = PH_QTAIL;
            byte_count_nxt = '0;
          end
        end
        PH_QTAIL: begin
          byte_count_nxt = bc_inc;
          if (bc_inc == QTAIL_LEN) begin
            byte_count_nxt     = '0;
            questions_left_nxt = qd_dec;
            phase_nxt = (qd_dec != '0) ? PH_QNAME : PH_ANAME_FIRST;
          end
        end
        PH_ANAME_FIRST: begin
          byte_count_nxt = '0;
          if (s1_byte_r == '0) phase_nxt = PH_FIXED;
          else if ((s1_byte_r & PTR_MASK) == '0) phase_nxt = PH_ANAME_REST;
          else phase_nxt = PH_APTR;
        end
        PH_ANAME_REST: begin
          if (s1_byte_r == '0) begin
            phase_nxt      = PH_FIXED;
            byte_count_nxt = '0;
          end
        end
        PH_APTR: begin
          phase_nxt      = PH_FIXED;
          byte_count_nxt = '0;
        end
        PH_FIXED: begin
          field_word_nxt = fw_shift;
          byte_count_nxt = bc_inc;
          if (byte_count_r == FIX_TYPE_LO) answer_type_nxt = fw_shift;
          else if (byte_count_r == FIX_CLASS_LO) answer_class_nxt = fw_shift;
          if (byte_count_r == FIX_LAST) begin
            byte_count_nxt = '0;
            if (answer_type_r == TYPE_A && answer_class_r == CLASS_IN) begin
              if (fw_shift != {{(WORD_W-CNT_W){1'b0}}, A_RDLEN}) begin
                hit = 1'b1;
              end else begin
                address_acc_nxt = '0;
                phase_nxt       = PH_ADDR;
              end
            end else if (fw_shift == '0) begin
              // zero-length rdata: move straight to the next answer, or decide when none is left
              answers_left_nxt = an_dec;
              if (an_dec == '0) hit = 1'b1;
              else phase_nxt = PH_ANAME_FIRST;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_ADDR: begin
          address_acc_nxt = acc_shift;
          byte_count_nxt  = bc_inc;
          if (bc_inc == A_RDLEN) begin
            hit        = 1'b1;
            hit_status = ST_OK;
          end
        end
        PH_SKIP: begin
          field_word_nxt = fw_dec;
          if (fw_dec == '0) begin
            answers_left_nxt = an_dec;
            if (an_dec == '0) hit = 1'b1;
            else phase_nxt = PH_ANAME_FIRST;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase

      if (hit) begin
        decided_nxt = 1'b1;
        res_valid   = 1'b1;
        res_status  = hit_status;
        res_address = (hit_status == ST_OK) ? acc_shift : '0;
      end else if (s1_last_r) begin
        res_valid = 1'b1;
      end
    end

    // End of packet: return all packet state to its idle value
    if (s1_fire && s1_last_r) begin
      phase_nxt          = PH_HEADER;
      byte_count_nxt     = '0;
      questions_left_nxt = '0;
      answers_left_nxt   = '0;
      field_word_nxt     = '0;
      answer_type_nxt    = '0;
      answer_class_nxt   = '0;
      address_acc_nxt    = '0;
      decided_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r    <= '0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      phase_r          <= PH_HEADER;
      byte_count_r     <= '0;
      questions_left_r <= '0;
      answers_left_r   <= '0;
      field_word_r     <= '0;
      answer_type_r    <= '0;
      answer_class_r   <= '0;
      address_acc_r    <= '0;
      decided_r        <= 1'b0;
    end else begin
      if (cfg_we) expected_id_r <= cfg_wdata;

      if (in_fire) begin
        s1_valid_r <= 1'b1;
        s1_byte_r  <= in_ch.data_byte;
        s1_last_r  <= in_ch.last_byte;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire && res_valid) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= res_status;
        out_address_r <= res_address;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      phase_r          <= phase_nxt;
      byte_count_r     <= byte_count_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      field_word_r     <= field_word_nxt;
      answer_type_r    <= answer_type_nxt;
      answer_class_r   <= answer_class_nxt;
      address_acc_r    <= address_acc_nxt;
      decided_r        <= decided_nxt;
    end
  end

endmodule

`default_nettype wire
